/* rtl/wmms_pkg.sv */
// ----------------------------------------------------------------------------
// wmms_pkg
// Shared types, constants and the microprogram for the windowed
// min/max/mean statistics block.
// ----------------------------------------------------------------------------
package wmms_pkg;

  localparam int unsigned DATA_W = 16;
  localparam int unsigned SUM_W  = 32;
  localparam int unsigned STEP_W = 4;

  localparam logic [DATA_W-1:0] LIMIT_RESET = DATA_W'(10);
  localparam logic [DATA_W-1:0] COUNT_FULL  = '1;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_UPDATE,
    OP_DSTART,
    OP_DSTORE,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    CH_X,
    CH_Y,
    CH_S
  } chan_sel_t;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_NO_IN,
    COND_DIV_BUSY,
    COND_OUT_FULL
  } cond_t;

  // One microcode word: the op runs only when the jump is not taken.
  typedef struct packed {
    op_t               op;
    chan_sel_t         chan;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } uword_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    op_t       op;
    chan_sel_t chan;
    logic      exec;
  } ctl_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic in_valid;
    logic div_busy;
    logic out_full;
  } stat_t;

  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
  } chan_st_t;

  localparam logic [STEP_W-1:0] ST_LOAD = STEP_W'(0);
  localparam logic [STEP_W-1:0] ST_WX   = STEP_W'(3);
  localparam logic [STEP_W-1:0] ST_WY   = STEP_W'(6);
  localparam logic [STEP_W-1:0] ST_WS   = STEP_W'(9);
  localparam logic [STEP_W-1:0] ST_EMIT = STEP_W'(11);

  // Microprogram: one item per pass.
  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    w = '{op: OP_NOP, chan: CH_X, cond: COND_ALWAYS, target: ST_LOAD};
    unique case (step)
      STEP_W'(0):  w = '{op: OP_LOAD,   chan: CH_X, cond: COND_NO_IN,    target: ST_LOAD};
      STEP_W'(1):  w = '{op: OP_UPDATE, chan: CH_X, cond: COND_NONE,     target: ST_LOAD};
      STEP_W'(2):  w = '{op: OP_DSTART, chan: CH_X, cond: COND_NONE,     target: ST_LOAD};
      STEP_W'(3):  w = '{op: OP_DSTORE, chan: CH_X, cond: COND_DIV_BUSY, target: ST_WX};
      STEP_W'(4):  w = '{op: OP_DSTART, chan: CH_Y, cond: COND_NONE,     target: ST_LOAD};
      STEP_W'(5):  w = '{op: OP_NOP,    chan: CH_Y, cond: COND_NONE,     target: ST_LOAD};
      STEP_W'(6):  w = '{op: OP_DSTORE, chan: CH_Y, cond: COND_DIV_BUSY, target: ST_WY};
      STEP_W'(7):  w = '{op: OP_DSTART, chan: CH_S, cond: COND_NONE,     target: ST_LOAD};
      STEP_W'(8):  w = '{op: OP_NOP,    chan: CH_S, cond: COND_NONE,     target: ST_LOAD};
      STEP_W'(9):  w = '{op: OP_DSTORE, chan: CH_S, cond: COND_DIV_BUSY, target: ST_WS};
      STEP_W'(10): w = '{op: OP_NOP,    chan: CH_X, cond: COND_NONE,     target: ST_LOAD};
      STEP_W'(11): w = '{op: OP_EMIT,   chan: CH_X, cond: COND_OUT_FULL, target: ST_EMIT};
      default:     w = '{op: OP_NOP,    chan: CH_X, cond: COND_ALWAYS,   target: ST_LOAD};
    endcase
    return w;
  endfunction

  // Fold one sample into a channel; a restart seeds it from the sample.
  function automatic chan_st_t chan_upd(input chan_st_t c, input logic [DATA_W-1:0] v,
                                        input logic restart);
    chan_st_t r;
    if (restart) begin
      r.sum = {{(SUM_W-DATA_W){1'b0}}, v};
      r.lo  = v;
      r.hi  = v;
    end else begin
      r.sum = c.sum + {{(SUM_W-DATA_W){1'b0}}, v};
      r.lo  = (v < c.lo) ? v : c.lo;
      r.hi  = (v > c.hi) ? v : c.hi;
    end
    return r;
  endfunction

endpackage

/* rtl/wmms_if.sv */
// ----------------------------------------------------------------------------
// wmms_if
// Valid/ready channel interfaces for samples and statistics results.
// ----------------------------------------------------------------------------
interface wmms_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] accel_x;
  logic [15:0] accel_y;
  logic [15:0] speed_sample;
  logic        logging_on;
  logic        flush_window;

  modport source (output valid, accel_x, accel_y, speed_sample, logging_on, flush_window,
                  input ready);
  modport sink   (input valid, accel_x, accel_y, speed_sample, logging_on, flush_window,
                  output ready);
endinterface

interface wmms_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample_count;
  logic [15:0] x_min;
  logic [15:0] x_max;
  logic [15:0] x_mean;
  logic [15:0] y_min;
  logic [15:0] y_max;
  logic [15:0] y_mean;
  logic [15:0] spd_min;
  logic [15:0] spd_max;
  logic [15:0] speed_mean;

  modport source (output valid, sample_count, x_min, x_max, x_mean, y_min, y_max, y_mean,
                  spd_min, spd_max, speed_mean, input ready);
  modport sink   (input valid, sample_count, x_min, x_max, x_mean, y_min, y_max, y_mean,
                  spd_min, spd_max, speed_mean, output ready);
endinterface

/* rtl/wmms_div.sv */
// ----------------------------------------------------------------------------
// wmms_div
// Restoring divider, one quotient bit per cycle, 32-bit sum by 16-bit count.
// ----------------------------------------------------------------------------
module wmms_div
  import wmms_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [SUM_W-1:0]    dividend,
  input  logic [DATA_W-1:0]   divisor,
  output logic                busy,
  output logic [DATA_W-1:0]   quotient
);

  localparam int unsigned ITER_W = $clog2(DATA_W);

  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] dsr;
  logic [ITER_W-1:0] iter;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;

  // The mean never exceeds the window maximum, so the upper half of the sum
  // is already below the count: seed the remainder with it and run 16 steps.
  assign trial    = {rem, quo[DATA_W-1]};
  assign diff     = trial - {1'b0, dsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && iter == ITER_W'(DATA_W - 1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= dividend[SUM_W-1:DATA_W];
      quo  <= dividend[DATA_W-1:0];
      dsr  <= divisor;
      iter <= '0;
    end else if (busy) begin
      if (!diff[DATA_W]) begin
        rem <= diff[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= trial[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
      iter <= iter + ITER_W'(1);
    end
  end

endmodule

/* rtl/wmms_seq.sv */
// ----------------------------------------------------------------------------
// wmms_seq
// Microcode sequencer: step counter, program table and conditional jumps.
// ----------------------------------------------------------------------------
module wmms_seq
  import wmms_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output ctl_t  ctl
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  uword_t            word;
  logic              jump;

  assign word = ucode(step);

  always_comb begin
    unique case (word.cond)
      COND_NONE:     jump = 1'b0;
      COND_ALWAYS:   jump = 1'b1;
      COND_NO_IN:    jump = !stat.in_valid;
      COND_DIV_BUSY: jump = stat.div_busy;
      COND_OUT_FULL: jump = stat.out_full;
      default:       jump = 1'b1;
    endcase
  end

  assign step_next = jump ? word.target : step + STEP_W'(1);

  assign ctl.op   = word.op;
  assign ctl.chan = word.chan;
  assign ctl.exec = !jump;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_LOAD;
    end else begin
      step <= step_next;
    end
  end

endmodule

/* rtl/wmms_dp.sv */
// ----------------------------------------------------------------------------
// wmms_dp
// Datapath: window state, shared divider, input capture and result register.
// ----------------------------------------------------------------------------
module wmms_dp
  import wmms_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [DATA_W-1:0] cfg_wr_data,
  input  ctl_t              ctl,
  output stat_t             stat,
  wmms_in_if.sink           in_ch,
  wmms_out_if.source        out_ch
);

  logic [DATA_W-1:0] window_limit;
  logic [DATA_W-1:0] count;
  chan_st_t          ch_x;
  chan_st_t          ch_y;
  chan_st_t          ch_s;
  logic              out_valid;

  logic [DATA_W-1:0] smp_x;
  logic [DATA_W-1:0] smp_y;
  logic [DATA_W-1:0] smp_s;
  logic              smp_log;
  logic              smp_flush;
  logic [DATA_W-1:0] mean_x;
  logic [DATA_W-1:0] mean_y;
  logic [DATA_W-1:0] mean_s;

  logic              restart;
  logic              div_start;
  logic              div_busy;
  logic [DATA_W-1:0] div_quo;
  logic [SUM_W-1:0]  div_sum;

  logic [DATA_W-1:0] o_count;
  logic [DATA_W-1:0] o_x_min, o_x_max, o_x_mean;
  logic [DATA_W-1:0] o_y_min, o_y_max, o_y_mean;
  logic [DATA_W-1:0] o_s_min, o_s_max, o_s_mean;

  assign restart = (count == '0) || (count == COUNT_FULL) ||
                   ((count > window_limit) && !smp_log);

  assign div_start = ctl.exec && (ctl.op == OP_DSTART);

  always_comb begin
    unique case (ctl.chan)
      CH_X:    div_sum = ch_x.sum;
      CH_Y:    div_sum = ch_y.sum;
      default: div_sum = ch_s.sum;
    endcase
  end

  wmms_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_sum),
    .divisor  (count),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  assign in_ch.ready   = (ctl.op == OP_LOAD);
  assign stat.in_valid = in_ch.valid;
  assign stat.div_busy = div_busy;
  assign stat.out_full = out_valid && !out_ch.ready;

  // Window state and control
  always_ff @(posedge clk) begin
    if (rst) begin
      window_limit <= LIMIT_RESET;
      count        <= '0;
      ch_x         <= '{sum: '0, lo: '1, hi: '0};
      ch_y         <= '{sum: '0, lo: '1, hi: '0};
      ch_s         <= '{sum: '0, lo: '0, hi: '0};
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        window_limit <= cfg_wr_data;
      end
      if (out_valid && out_ch.ready && !(ctl.exec && ctl.op == OP_EMIT)) begin
        out_valid <= 1'b0;
      end
      if (ctl.exec) begin
        unique case (ctl.op)
          OP_UPDATE: begin
            count <= restart ? DATA_W'(1) : count + DATA_W'(1);
            ch_x  <= chan_upd(ch_x, smp_x, restart);
            ch_y  <= chan_upd(ch_y, smp_y, restart);
            ch_s  <= chan_upd(ch_s, smp_s, restart);
          end
          OP_EMIT: begin
            out_valid <= 1'b1;
            if (smp_flush) begin
              count <= '0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Sample capture, means and result payload
  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      unique case (ctl.op)
        OP_LOAD: begin
          smp_x     <= in_ch.accel_x;
          smp_y     <= in_ch.accel_y;
          smp_s     <= in_ch.speed_sample;
          smp_log   <= in_ch.logging_on;
          smp_flush <= in_ch.flush_window;
        end
        OP_DSTORE: begin
          unique case (ctl.chan)
            CH_X:    mean_x <= div_quo;
            CH_Y:    mean_y <= div_quo;
            default: mean_s <= div_quo;
          endcase
        end
        OP_EMIT: begin
          o_count  <= count;
          o_x_min  <= ch_x.lo;
          o_x_max  <= ch_x.hi;
          o_x_mean <= mean_x;
          o_y_min  <= ch_y.lo;
          o_y_max  <= ch_y.hi;
          o_y_mean <= mean_y;
          o_s_min  <= ch_s.lo;
          o_s_max  <= ch_s.hi;
          o_s_mean <= mean_s;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.sample_count = o_count;
  assign out_ch.x_min        = o_x_min;
  assign out_ch.x_max        = o_x_max;
  assign out_ch.x_mean       = o_x_mean;
  assign out_ch.y_min        = o_y_min;
  assign out_ch.y_max        = o_y_max;
  assign out_ch.y_mean       = o_y_mean;
  assign out_ch.spd_min      = o_s_min;
  assign out_ch.spd_max      = o_s_max;
  assign out_ch.speed_mean   = o_s_mean;

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    ctl.exec && ctl.op == OP_UPDATE |=> count != '0)
    else $error("window count is zero after an update");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    ctl.exec && ctl.op == OP_EMIT |=> out_valid)
    else $error("result not presented after emit");

  a_minmax_order: assert property (@(posedge clk) disable iff (rst)
    count != '0 |-> ch_x.lo <= ch_x.hi && ch_y.lo <= ch_y.hi && ch_s.lo <= ch_s.hi)
    else $error("channel minimum above maximum in an open window");

endmodule

/* rtl/windowed_min_max_mean_stats.sv */
// ----------------------------------------------------------------------------
// windowed_min_max_mean_stats
// Running minimum, maximum and floor mean over a restartable sample window
// for X acceleration, Y acceleration and speed.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake        Carries
//  in_ch     in   valid / ready    accel_x, accel_y, speed_sample, logging_on,
//                                  flush_window
//  out_ch    out  valid / ready    sample_count and min / max / mean per channel
//  cfg       in   cfg_wr_en        cfg_wr_data -> window_limit (reset 10)
//
//  A sample transfers only in the load step, so the next one waits until the
//  program has returned there. One shared restoring divider produces the three
//  means one after another (start, 16 quotient bits, store each) after the load
//  and update steps; then come one spare step, emit (held while out_ch is full)
//  and the return to the load step.
//  Reset (synchronous, rst high) empties the window, loads window_limit with
//  10 and returns the microprogram to its load step.
//  The result sits in an output register; the next sample transfer is taken
//  while it waits, and only the emit step holds until out_ch frees up.
//
module windowed_min_max_mean_stats
  import wmms_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [DATA_W-1:0] cfg_wr_data,
  wmms_in_if.sink           in_ch,
  wmms_out_if.source        out_ch
);

  // Control word for the current step, and status fed back for jumps.
  ctl_t  ctl;
  stat_t stat;

  // Sequencer walks the program: load, update window, three divides, emit.
  wmms_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  // Datapath holds the window, the divider and the result register.
  wmms_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .ctl         (ctl),
    .stat        (stat),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

endmodule
